FILE: sv/ps2mpd_pkg.sv
// Package for the PS/2 mouse packet decoder: packet phase type, header bit
// positions and beat layout constants. No dependencies.
`default_nettype none

package ps2mpd_pkg;

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2,
    PH_SPARE = 2'd3
  } phase_e;

  // header byte bit positions
  localparam int unsigned HdrBtnLeft   = 0;
  localparam int unsigned HdrBtnRight  = 1;
  localparam int unsigned HdrBtnMiddle = 2;
  localparam int unsigned HdrSync      = 3;
  localparam int unsigned HdrXSign     = 4;
  localparam int unsigned HdrYSign     = 5;

  localparam int unsigned RxWidth    = 8;
  localparam int unsigned MoveXWidth = 9;
  localparam int unsigned MoveYWidth = 10;
  localparam int unsigned OutWidth   = 24;

  localparam logic       KindButton = 1'b0;
  localparam logic       KindMove   = 1'b1;

  localparam logic [1:0] BtnIdLeft   = 2'd0;
  localparam logic [1:0] BtnIdMiddle = 2'd1;
  localparam logic [1:0] BtnIdRight  = 2'd2;

endpackage

`default_nettype wire

FILE: sv/ps2_mouse_packet_decoder.sv
// PS/2 mouse three-byte packet decoder (single module).
// Depends on ps2mpd_pkg for the phase type and header bit positions.
//
// Usage:
//   Slave stream carries received mouse bytes, one byte per beat. Master
//   stream carries decoded events, one event per beat; tuser gives the event
//   kind and tlast marks the last event caused by one byte. A header byte
//   without its sync bit is dropped. A header produces 0 to 3 button events
//   (left, middle, right); the third byte produces one movement event unless
//   both deltas are zero.
// Path: byte -> pending event slots -> output register -> master side.
// Throughput: one byte per cycle while each byte yields at most one event and
//   the master side is ready; a header with more than one changed button holds
//   the slave side until its last event is loaded into the output register. The
//   limit is the single output register draining one event per cycle.
// Reset: phase returns to header search, button levels all released, no
//   pending or output events.
// Stall: while the master side is stalled the output register holds its
//   beat; the pending slots fill and tready drops until they drain.
`default_nettype none

module ps2_mouse_packet_decoder (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [ps2mpd_pkg::RxWidth-1:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [1:0] button_id, [2] pressed, [11:3] move_x, [21:12] move_y,
  // [23:22] zero pad
  output logic [ps2mpd_pkg::OutWidth-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tuser_o,   // [0] event_kind
  output logic                                m_axis_tlast_o    // last
);
  import ps2mpd_pkg::*;

  // packet framing state
  phase_e                  phase_q, phase_d;
  logic [RxWidth-1:0]      header_q, header_d;
  logic [RxWidth-1:0]      xbyte_q, xbyte_d;
  logic [2:0]              btn_q, btn_d;        // header order: left, right, middle

  // pending event slots: [0] left, [1] middle, [2] right, [3] movement
  logic [3:0]              pend_q, pend_d;
  logic [2:0]              lvl_q, lvl_d;        // new levels: left, middle, right
  logic [MoveXWidth-1:0]   mx_q, mx_d;
  logic [MoveYWidth-1:0]   my_q, my_d;

  // output register
  logic                    ovalid_q, ovalid_d;
  logic                    okind_q, okind_d;
  logic [1:0]              oid_q, oid_d;
  logic                    opress_q, opress_d;
  logic [MoveXWidth-1:0]   omx_q, omx_d;
  logic [MoveYWidth-1:0]   omy_q, omy_d;
  logic                    olast_q, olast_d;

  logic                    in_acc;
  logic                    load;
  logic [3:0]              pick;
  logic [3:0]              pend_left;
  logic [2:0]              newb;
  logic [2:0]              chg;
  logic                    move_hit;
  logic [MoveYWidth-1:0]   dy_ext;

  assign load      = (pend_q != 4'd0) && (!ovalid_q || m_axis_tready_i);
  assign pick      = pend_q & (~pend_q + 4'd1);
  assign pend_left = load ? (pend_q & ~pick) : pend_q;
  assign s_axis_tready_o = (pend_left == 4'd0);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;

  assign newb = s_axis_tdata_i[2:0];
  // change flags in event order: left, middle, right
  assign chg  = {newb[HdrBtnRight] ^ btn_q[HdrBtnRight],
                 newb[HdrBtnMiddle] ^ btn_q[HdrBtnMiddle],
                 newb[HdrBtnLeft] ^ btn_q[HdrBtnLeft]};
  assign move_hit = (xbyte_q != '0) || (s_axis_tdata_i != '0);
  assign dy_ext   = {{(MoveYWidth-RxWidth){header_q[HdrYSign]}}, s_axis_tdata_i};

  // next phase and framing registers
  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    xbyte_d  = xbyte_q;
    btn_d    = btn_q;
    if (in_acc) begin
      unique case (phase_q)
        PH_HDR: begin
          if (s_axis_tdata_i[HdrSync]) begin
            phase_d  = PH_X;
            header_d = s_axis_tdata_i;
            btn_d    = newb;
          end
        end
        PH_X: begin
          phase_d = PH_Y;
          xbyte_d = s_axis_tdata_i;
        end
        PH_Y: begin
          phase_d  = PH_HDR;
          header_d = '0;
          xbyte_d  = '0;
        end
        PH_SPARE: phase_d = PH_HDR;
        default:  phase_d = PH_HDR;
      endcase
    end
  end

  // event generation into pending slots
  always_comb begin
    pend_d = pend_left;
    lvl_d  = lvl_q;
    mx_d   = mx_q;
    my_d   = my_q;
    if (in_acc) begin
      unique case (phase_q)
        PH_HDR: begin
          if (s_axis_tdata_i[HdrSync]) begin
            pend_d = {1'b0, chg};
            lvl_d  = {newb[HdrBtnRight], newb[HdrBtnMiddle], newb[HdrBtnLeft]};
          end
        end
        PH_Y: begin
          pend_d = {move_hit, 3'b000};
          mx_d   = {header_q[HdrXSign], xbyte_q};
          my_d   = ~dy_ext + MoveYWidth'(1);
        end
        PH_X, PH_SPARE: pend_d = pend_left;
        default:        pend_d = pend_left;
      endcase
    end
  end

  // output register load
  always_comb begin
    ovalid_d = ovalid_q;
    okind_d  = okind_q;
    oid_d    = oid_q;
    opress_d = opress_q;
    omx_d    = omx_q;
    omy_d    = omy_q;
    olast_d  = olast_q;
    if (load) begin
      ovalid_d = 1'b1;
      olast_d  = (pend_q & ~pick) == 4'd0;
      okind_d  = KindButton;
      oid_d    = BtnIdLeft;
      opress_d = 1'b0;
      omx_d    = '0;
      omy_d    = '0;
      priority if (pick[3]) begin
        okind_d = KindMove;
        omx_d   = mx_q;
        omy_d   = my_q;
      end else if (pick[2]) begin
        oid_d    = BtnIdRight;
        opress_d = lvl_q[2];
      end else if (pick[1]) begin
        oid_d    = BtnIdMiddle;
        opress_d = lvl_q[1];
      end else begin
        oid_d    = BtnIdLeft;
        opress_d = lvl_q[0];
      end
    end else if (m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      header_q <= '0;
      xbyte_q  <= '0;
      btn_q    <= '0;
      pend_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      header_q <= header_d;
      xbyte_q  <= xbyte_d;
      btn_q    <= btn_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
    okind_q  <= okind_d;
    oid_q    <= oid_d;
    opress_q <= opress_d;
    omx_q    <= omx_d;
    omy_q    <= omy_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {2'b00, omy_q, omx_q, opress_q, oid_q};
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

  // movement and button events never wait together
  a_pend_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q[3] |-> (pend_q[2:0] == 3'b000))
    else $error("movement pending alongside button events");

  // a movement event always closes its byte
  a_move_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KindMove) |-> m_axis_tlast_o)
    else $error("movement event without tlast");

  // header without sync bit is dropped
  a_sync_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_HDR && !s_axis_tdata_i[HdrSync])
      |=> (phase_q == PH_HDR && pend_q == 4'd0))
    else $error("unsynced header byte not dropped");

  // ready only when at most one pending event is left
  a_ready_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> ($countones(pend_q) <= 1))
    else $error("input taken with several events pending");

endmodule

`default_nettype wire

FILE: sim/ps2mpd_checker.sv
// Scoreboard for the PS/2 mouse packet decoder: watches the byte and event
// streams, predicts the events of each accepted byte and compares them.
// Depends on ps2mpd_pkg for the phase type, header bit positions and codes.
module ps2mpd_checker
  import ps2mpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rx_valid_i,
  input  wire logic                rx_ready_i,
  input  wire logic [RxWidth-1:0]  rx_byte_i,
  input  wire logic                ev_valid_i,
  input  wire logic                ev_ready_i,
  input  wire logic [OutWidth-1:0] ev_data_i,
  input  wire logic                ev_user_i,
  input  wire logic                ev_last_i,
  output int                       mismatches_o,
  output int                       events_due_o,
  output int                       button_events_o,
  output int                       move_events_o,
  output int                       dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  kind;
    logic [1:0]            btn;
    logic                  pressed;
    logic [MoveXWidth-1:0] dx;
    logic [MoveYWidth-1:0] dy;
    logic                  last;
  } mouse_event_t;

  // decoder state as seen by the predictor
  phase_e       phase = PH_HDR;
  logic [7:0]   hdr = '0;
  logic [7:0]   xb = '0;
  logic [2:0]   levels = '0;  // header bit order: left, right, middle

  mouse_event_t pending_events[$];

  initial begin
    mismatches_o = 0;
    events_due_o = 0;
    button_events_o = 0;
    move_events_o = 0;
    dropped_o = 0;
  end

  task automatic decode_rx_byte(input logic [7:0] b);
    int unsigned  pos[3] = '{HdrBtnLeft, HdrBtnMiddle, HdrBtnRight};
    logic [1:0]   ids[3] = '{BtnIdLeft, BtnIdMiddle, BtnIdRight};
    mouse_event_t evs[$];
    mouse_event_t ev;
    case (phase)
      PH_HDR: begin
        if (!b[HdrSync]) begin
          dropped_o++;
        end else begin
          hdr = b;
          phase = PH_X;
          // events go out left, middle, right
          for (int i = 0; i < 3; i++) begin
            if (b[pos[i]] != levels[pos[i]]) begin
              ev = '0;
              ev.kind = KindButton;
              ev.btn = ids[i];
              ev.pressed = b[pos[i]];
              evs.push_back(ev);
            end
          end
          levels = b[2:0];
        end
      end
      PH_X: begin
        xb = b;
        phase = PH_Y;
      end
      PH_Y: begin
        phase = PH_HDR;
        if (xb != 0 || b != 0) begin
          ev = '0;
          ev.kind = KindMove;
          ev.dx = {hdr[HdrXSign], xb};
          ev.dy = 10'd0 - {{2{hdr[HdrYSign]}}, b};
          evs.push_back(ev);
        end
        hdr = '0;
        xb = '0;
      end
      default: begin
        phase = PH_HDR;
      end
    endcase
    if (evs.size() != 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endtask

  task automatic note_mismatch(input mouse_event_t want, input mouse_event_t got,
                               input bit orphan);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      if (orphan) begin
        $display("[%0t] orphan event: kind %0d btn %0d pr %0d x %0d y %0d last %0d",
                 $realtime, got.kind, got.btn, got.pressed, $signed(got.dx),
                 $signed(got.dy), got.last);
      end else begin
        $display("[%0t] mismatch: exp kind %0d btn %0d pr %0d x %0d y %0d last %0d",
                 $realtime, want.kind, want.btn, want.pressed, $signed(want.dx),
                 $signed(want.dy), want.last);
        $display("               got kind %0d btn %0d pr %0d x %0d y %0d last %0d",
                 got.kind, got.btn, got.pressed, $signed(got.dx), $signed(got.dy),
                 got.last);
      end
    end
  endtask

  task automatic check_event(input logic [OutWidth-1:0] d, input logic u,
                             input logic l);
    mouse_event_t got;
    mouse_event_t want;
    got.kind = u;
    got.btn = d[1:0];
    got.pressed = d[2];
    got.dx = d[11:3];
    got.dy = d[21:12];
    got.last = l;
    if (got.kind === KindMove) move_events_o++;
    else button_events_o++;
    if (pending_events.size() == 0) begin
      note_mismatch('0, got, 1'b1);
    end else begin
      want = pending_events.pop_front();
      if (got.kind !== want.kind || got.btn !== want.btn ||
          got.pressed !== want.pressed || got.dx !== want.dx ||
          got.dy !== want.dy || got.last !== want.last) begin
        note_mismatch(want, got, 1'b0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_i) decode_rx_byte(rx_byte_i);
      if (ev_valid_i && ev_ready_i) check_event(ev_data_i, ev_user_i, ev_last_i);
      events_due_o = pending_events.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// Top of the PS/2 mouse packet decoder testbench: clock, reset, byte stimulus
// and event back-pressure, verdict. Depends on ps2mpd_pkg, the decoder and
// ps2mpd_checker.
module tb_top;
  import ps2mpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBytes = 324;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 200000;

  localparam int DirCount = 26;
  localparam logic [7:0] DirBytes[DirCount] = '{
    8'h00, 8'hF7,            // no sync bit: dropped
    8'h08, 8'h00, 8'h00,     // no button change, zero motion
    8'h0F, 8'h7F, 8'h80,     // all three pressed, large positive deltas
    8'h38, 8'h00, 8'h00,     // all released, sign bits on zero deltas
    8'hFF, 8'hFF, 8'hFF,     // overflow bits set, deltas of -1
    8'h38, 8'h00, 8'h01,     // x -256, y -255
    8'h2D, 8'h01, 8'h00,     // left and middle, y -256
    8'h0A, 8'hFF, 8'h00,     // right only, x 255
    8'h19, 8'h00, 8'h7F      // left only, x -256 from zero byte
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [RxWidth-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  int mismatches;
  int events_due;
  int button_events;
  int move_events;
  int dropped;

  int  rx_sent = 0;
  int  burst_left = 0;
  int  cycle_count = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  ps2_mouse_packet_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  ps2mpd_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (s_tvalid),
    .rx_ready_i      (s_tready),
    .rx_byte_i       (s_tdata),
    .ev_valid_i      (m_tvalid),
    .ev_ready_i      (m_tready),
    .ev_data_i       (m_tdata),
    .ev_user_i       (m_tuser),
    .ev_last_i       (m_tlast),
    .mismatches_o    (mismatches),
    .events_due_o    (events_due),
    .button_events_o (button_events),
    .move_events_o   (move_events),
    .dropped_o       (dropped)
  );

  // called at a falling edge; returns at the falling edge after the beat
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    rx_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r < 6) return 8'($urandom_range(0, 7)) ^ {8{r[0]}};
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int r;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirCount; i++) offer_byte(DirBytes[i]);

    while (rx_sent < DirCount + RandomBytes) begin
      if (rx_sent >= DirCount + 120) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        offer_byte(8'($urandom_range(0, 255)));          // stray byte
      end else if (r < 13) begin
        offer_byte(8'($urandom_range(0, 255)) | 8'h08);  // truncated packet
        offer_byte(pick_delta());
      end else begin
        offer_byte(8'($urandom_range(0, 255)) | 8'h08);
        offer_byte(pick_delta());
        offer_byte(pick_delta());
      end
    end
    s_tvalid <= 1'b0;

    while (events_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d bytes (%0d unsynced drops), %0d button and %0d motion events,",
             rx_sent, dropped, button_events, move_events);
    $display("with bursty input and a %0d-cycle output hold-off.", HoldCycles);
    if (mismatches == 0 && events_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // event side back-pressure: random modes, plus one long hold-off
  initial begin
    int mode;
    int span;
    int tick;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk_i);
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (tick % 5 != 0) && (tick % 7 != 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d events still due", cycle_count, events_due);
      $display("FAILURE");
      $finish;
    end
  end

endmodule
